// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the cache model RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SLAC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SLAC_ASSERT_NEVER(name, cond, msg) \
  `SLAC_ASSERT(name, !(cond), msg)

`endif

// File: hw/rtl/slac_pkg.sv
// Package for the set-associative LRU cache hit model.
// Holds widths, register indexes, codes, the tag entry layout and the FSM type.
// No dependencies.
`default_nettype none

package slac_pkg;

  localparam int unsigned AddrW      = 32;
  localparam int unsigned OffsBits   = 5;
  localparam int unsigned LineW      = AddrW - OffsBits;
  localparam int unsigned TagW       = 27;
  localparam int unsigned RankW      = 4;
  localparam int unsigned WayIdxW    = 4;
  localparam int unsigned WayCntW    = WayIdxW + 1;
  localparam int unsigned NumEntries = 1024;
  localparam int unsigned EntryAddrW = $clog2(NumEntries);
  localparam int unsigned CountW     = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CfgCacheSize = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgWays      = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgAlloc     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgPrefetch  = CfgIdxW'(3);

  localparam logic [3:0] SizeLog2Min = 4'd10;
  localparam logic [3:0] SizeLog2Max = 4'd15;
  localparam logic [2:0] WaysLog2Max = 3'd4;

  localparam logic       OpStore  = 1'b1;
  localparam logic [1:0] PfOff    = 2'd0;
  localparam logic [1:0] PfAlways = 2'd1;
  localparam logic [1:0] PfOnMiss = 2'd2;

  localparam logic [3:0] SizeLog2Rst = 4'd14;
  localparam logic [2:0] WaysLog2Rst = 3'd1;
  localparam logic       AllocRst    = 1'b1;

  localparam logic [RankW-1:0] RankMax = '1;

  typedef struct packed {
    logic             valid;
    logic [RankW-1:0] rank;
    logic [TagW-1:0]  tag;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic               hit;
    logic [WayIdxW-1:0] hit_way;
    logic [RankW-1:0]   hit_rank;
    logic               inv;
    logic [WayIdxW-1:0] inv_way;
    logic [RankW-1:0]   max_rank;
    logic [WayIdxW-1:0] max_way;
  } scan_res_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StScan,
    StDecide,
    StUpdate,
    StDone
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/slac_req_if.sv
// Request channel of the cache model: one load or store address per transfer.
// Depends on slac_pkg for the field widths.
`default_nettype none

interface slac_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [slac_pkg::AddrW-1:0]  address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/slac_rsp_if.sv
// Response channel of the cache model: hit flags and the running hit count.
// Depends on slac_pkg for the field widths.
`default_nettype none

interface slac_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         prefetch_present;
  logic [slac_pkg::CountW-1:0]  hit_count;

  modport source (output valid, output hit, output prefetch_present, output hit_count,
                  input ready);
  modport sink   (input valid, input hit, input prefetch_present, input hit_count,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/set_assoc_lru_cache_hit_model.sv
// Set-associative LRU cache hit model, top level.
// Uses slac_pkg, slac_req_if, slac_rsp_if, slac_ram, slac_way_eval and assert_macros.svh.
//
// Each request transfer carries an opcode (load or store) and a byte address. The block
// looks the line up in a tag RAM of 1024 entries, updates the LRU ranks, fills on a miss
// (a store miss only when allocation is on) and optionally looks up and fills the next
// line. One response transfer follows each request with the hit flag, the prefetch-present
// flag and the saturating hit count. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i. A set is walked one way per cycle through a single tag compare
// unit and a single RAM read port. Each set is scanned in StScan, the way to access is
// chosen in StDecide and, when the set is accessed, its ranks and tag are written back
// in StUpdate. When the next line is looked up, its set then follows the same steps.
// The response is registered in StDone; the next request is taken only after that, so
// one item is handled at a time.
// After reset, and after each write to the size or ways register, a clearing pass
// invalidates every one of the 1024 entries; no request is taken during that pass.
// The response sits in an output register; the next request is taken while it waits,
// but the block holds its next result until the receiver has taken the previous one.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_lru_cache_hit_model (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  slac_req_if.sink                           req_i,
  slac_rsp_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [slac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [slac_pkg::CfgDataW-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic [3:0] size_q;
  logic [2:0] ways_q;
  logic       alloc_q;
  logic [1:0] pf_mode_q;

  logic geom_wr;
  assign geom_wr = cfg_we_i &&
                   ((cfg_idx_i == slac_pkg::CfgCacheSize) || (cfg_idx_i == slac_pkg::CfgWays));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= slac_pkg::SizeLog2Rst;
      ways_q    <= slac_pkg::WaysLog2Rst;
      alloc_q   <= slac_pkg::AllocRst;
      pf_mode_q <= slac_pkg::PfOff;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        slac_pkg::CfgCacheSize: size_q    <= cfg_wdata_i[3:0];
        slac_pkg::CfgWays:      ways_q    <= cfg_wdata_i[2:0];
        slac_pkg::CfgAlloc:     alloc_q   <= cfg_wdata_i[0];
        slac_pkg::CfgPrefetch:  pf_mode_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Geometry.
  logic [3:0]                         size_eff;
  logic [2:0]                         wl;
  logic [3:0]                         sets_log2;
  logic [slac_pkg::WayCntW-1:0]       num_ways;
  logic [slac_pkg::EntryAddrW:0]      sets_one;
  logic [slac_pkg::EntryAddrW-1:0]    idx_mask;
  logic [slac_pkg::LineW-1:0]         d_line, p_line;
  logic [slac_pkg::EntryAddrW-1:0]    d_idx, p_idx, d_base, p_base;
  logic [slac_pkg::TagW-1:0]          d_tag, p_tag;

  always_comb begin
    if (size_q < slac_pkg::SizeLog2Min) begin
      size_eff = slac_pkg::SizeLog2Min;
    end else if (size_q > slac_pkg::SizeLog2Max) begin
      size_eff = slac_pkg::SizeLog2Max;
    end else begin
      size_eff = size_q;
    end
    wl        = (ways_q > slac_pkg::WaysLog2Max) ? slac_pkg::WaysLog2Max : ways_q;
    sets_log2 = size_eff - 4'(slac_pkg::OffsBits) - {1'b0, wl};
    num_ways  = slac_pkg::WayCntW'(1) << wl;
    sets_one  = (slac_pkg::EntryAddrW + 1)'(1) << sets_log2;
    idx_mask  = sets_one[slac_pkg::EntryAddrW-1:0] - slac_pkg::EntryAddrW'(1);
    d_line    = req_i.address[slac_pkg::AddrW-1:slac_pkg::OffsBits];
    p_line    = d_line + slac_pkg::LineW'(1);
    d_idx     = d_line[slac_pkg::EntryAddrW-1:0] & idx_mask;
    p_idx     = p_line[slac_pkg::EntryAddrW-1:0] & idx_mask;
    d_base    = d_idx << wl;
    p_base    = p_idx << wl;
    d_tag     = slac_pkg::TagW'(d_line >> sets_log2);
    p_tag     = slac_pkg::TagW'(p_line >> sets_log2);
  end

  // Sequencer state and datapath registers.
  slac_pkg::state_e                   state_q, state_d;
  logic [slac_pkg::WayCntW-1:0]       cnt_q;
  logic                               rvalid_q;
  logic [slac_pkg::WayIdxW-1:0]       rway_q;
  logic [slac_pkg::EntryAddrW-1:0]    clr_cnt_q;
  logic                               pf_phase_q;
  logic                               op_q;
  logic [slac_pkg::EntryAddrW-1:0]    dbase_q, pbase_q;
  logic [slac_pkg::TagW-1:0]          dtag_q, ptag_q;
  logic                               hit_q, pf_present_q;
  logic [slac_pkg::CountW-1:0]        hit_cnt_q;
  logic [slac_pkg::WayIdxW-1:0]       acc_way_q;
  logic [slac_pkg::WayCntW-1:0]       limit_q;
  logic                               fill_q;
  logic                               out_valid_q, out_hit_q, out_pf_q;
  logic [slac_pkg::CountW-1:0]        out_cnt_q;

  logic                               in_xfer, out_free, issue, phase_end, scan_start;
  logic                               hit_sel, check_pf;
  logic [slac_pkg::EntryAddrW-1:0]    cur_base;
  logic [slac_pkg::TagW-1:0]          cur_tag;
  logic                               dec_act, dec_fill;
  logic [slac_pkg::WayIdxW-1:0]       dec_way;
  logic [slac_pkg::WayCntW-1:0]       dec_limit;
  slac_pkg::scan_res_t                scan_res;
  slac_pkg::entry_t                   rd_entry, upd_entry;

  logic                               ram_we;
  logic [slac_pkg::EntryAddrW-1:0]    ram_waddr, ram_raddr;
  logic [slac_pkg::EntryW-1:0]        ram_wdata, ram_rdata;

  assign in_xfer   = req_i.valid && req_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign cur_base  = pf_phase_q ? pbase_q : dbase_q;
  assign cur_tag   = pf_phase_q ? ptag_q : dtag_q;
  assign phase_end = (cnt_q == num_ways) && !rvalid_q;
  assign rd_entry  = slac_pkg::entry_t'(ram_rdata);

  assign hit_sel  = ((state_q == slac_pkg::StDecide) && !pf_phase_q) ? scan_res.hit : hit_q;
  assign check_pf = (pf_mode_q == slac_pkg::PfAlways) ||
                    ((pf_mode_q == slac_pkg::PfOnMiss) && !hit_sel);

  // Access decision for the set just scanned.
  always_comb begin
    if (scan_res.hit) begin
      dec_act   = 1'b1;
      dec_fill  = 1'b0;
      dec_way   = scan_res.hit_way;
      dec_limit = {1'b0, scan_res.hit_rank};
    end else begin
      dec_act   = pf_phase_q || (op_q != slac_pkg::OpStore) || alloc_q;
      dec_fill  = 1'b1;
      dec_way   = scan_res.inv ? scan_res.inv_way : scan_res.max_way;
      dec_limit = scan_res.inv ? num_ways : {1'b0, scan_res.max_rank};
    end
  end

  // Rank and tag write-back for one way.
  always_comb begin
    upd_entry = rd_entry;
    if (rway_q == acc_way_q) begin
      upd_entry.valid = 1'b1;
      upd_entry.rank  = '0;
      if (fill_q) begin
        upd_entry.tag = cur_tag;
      end
    end else if (rd_entry.valid && ({1'b0, rd_entry.rank} < limit_q) &&
                 (rd_entry.rank != slac_pkg::RankMax)) begin
      upd_entry.rank = rd_entry.rank + slac_pkg::RankW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      slac_pkg::StClear: begin
        if (clr_cnt_q == slac_pkg::EntryAddrW'(slac_pkg::NumEntries - 1)) begin
          state_d = slac_pkg::StIdle;
        end
      end
      slac_pkg::StIdle: begin
        if (in_xfer) begin
          state_d = slac_pkg::StScan;
        end
      end
      slac_pkg::StScan: begin
        if (phase_end) begin
          state_d = slac_pkg::StDecide;
        end
      end
      slac_pkg::StDecide: begin
        if (dec_act) begin
          state_d = slac_pkg::StUpdate;
        end else if (!pf_phase_q && check_pf) begin
          state_d = slac_pkg::StScan;
        end else begin
          state_d = slac_pkg::StDone;
        end
      end
      slac_pkg::StUpdate: begin
        if (phase_end) begin
          state_d = (!pf_phase_q && check_pf) ? slac_pkg::StScan : slac_pkg::StDone;
        end
      end
      slac_pkg::StDone: begin
        if (out_free) begin
          state_d = slac_pkg::StIdle;
        end
      end
      default: state_d = slac_pkg::StIdle;
    endcase
    if (geom_wr) begin
      state_d = slac_pkg::StClear;
    end
  end

  // Sequencer outputs.
  always_comb begin
    req_i.ready = (state_q == slac_pkg::StIdle) && !geom_wr;
    issue       = ((state_q == slac_pkg::StScan) || (state_q == slac_pkg::StUpdate)) &&
                  (cnt_q < num_ways);
    scan_start  = (state_d == slac_pkg::StScan) && (state_q != slac_pkg::StScan);
    ram_raddr   = cur_base + slac_pkg::EntryAddrW'(cnt_q[slac_pkg::WayIdxW-1:0]);
    ram_we      = 1'b0;
    ram_waddr   = cur_base + slac_pkg::EntryAddrW'(rway_q);
    ram_wdata   = upd_entry;
    case (state_q)
      slac_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      slac_pkg::StUpdate: begin
        ram_we = rvalid_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= slac_pkg::StClear;
      cnt_q        <= '0;
      rvalid_q     <= 1'b0;
      clr_cnt_q    <= '0;
      pf_phase_q   <= 1'b0;
      hit_q        <= 1'b0;
      pf_present_q <= 1'b0;
      hit_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= issue;
      if (state_d != state_q) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + slac_pkg::WayCntW'(1);
      end
      if (geom_wr) begin
        clr_cnt_q <= '0;
      end else if (state_q == slac_pkg::StClear) begin
        clr_cnt_q <= clr_cnt_q + slac_pkg::EntryAddrW'(1);
      end
      if (in_xfer) begin
        pf_phase_q   <= 1'b0;
        pf_present_q <= 1'b0;
      end else if (scan_start) begin
        pf_phase_q <= 1'b1;
      end
      if (state_q == slac_pkg::StDecide) begin
        if (pf_phase_q) begin
          pf_present_q <= scan_res.hit;
        end else begin
          hit_q <= scan_res.hit;
          if (scan_res.hit && (hit_cnt_q != '1)) begin
            hit_cnt_q <= hit_cnt_q + slac_pkg::CountW'(1);
          end
        end
      end
      if ((state_q == slac_pkg::StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rway_q <= cnt_q[slac_pkg::WayIdxW-1:0];
    if (in_xfer) begin
      op_q    <= req_i.opcode;
      dbase_q <= d_base;
      pbase_q <= p_base;
      dtag_q  <= d_tag;
      ptag_q  <= p_tag;
    end
    if (state_q == slac_pkg::StDecide) begin
      acc_way_q <= dec_way;
      limit_q   <= dec_limit;
      fill_q    <= dec_fill;
    end
    if ((state_q == slac_pkg::StDone) && out_free) begin
      out_hit_q <= hit_q;
      out_pf_q  <= pf_present_q;
      out_cnt_q <= hit_cnt_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.hit              = out_hit_q;
  assign rsp_o.prefetch_present = out_pf_q;
  assign rsp_o.hit_count        = out_cnt_q;

  slac_ram #(
    .Width (slac_pkg::EntryW),
    .Depth (slac_pkg::NumEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  slac_way_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .valid_i (rvalid_q && (state_q == slac_pkg::StScan)),
    .way_i   (rway_q),
    .entry_i (rd_entry),
    .tag_i   (cur_tag),
    .res_o   (scan_res)
  );

  `SLAC_ASSERT_NEVER(a_no_rw_collision, ram_we && issue && (ram_waddr == ram_raddr),
                     "tag RAM read and write hit the same entry in one cycle")
  `SLAC_ASSERT(a_accept_starts_scan, in_xfer |=> (state_q == slac_pkg::StScan),
               "accepted request did not start a set scan")
  `SLAC_ASSERT(a_count_monotonic, 1'b1 |=> (hit_cnt_q >= $past(hit_cnt_q)),
               "hit counter decreased")
  `SLAC_ASSERT(a_hit_has_count, (out_valid_q && out_hit_q) |-> (out_cnt_q != '0),
               "hit reported with a zero hit count")

endmodule

`default_nettype wire

// File: hw/rtl/slac_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module slac_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/slac_way_eval.sv
// Way scan unit: checks one tag entry per cycle while valid_i is high and collects
// the hit way, the lowest invalid way and the way with the largest rank. Uses slac_pkg.
`default_nettype none

module slac_way_eval (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         valid_i,
  input  wire logic [slac_pkg::WayIdxW-1:0] way_i,
  input  wire slac_pkg::entry_t             entry_i,
  input  wire logic [slac_pkg::TagW-1:0]    tag_i,
  output slac_pkg::scan_res_t               res_o
);

  slac_pkg::scan_res_t res_q, res_d;

  always_comb begin
    res_d = res_q;
    if (start_i) begin
      res_d = '0;
    end else if (valid_i) begin
      if (entry_i.valid && (entry_i.tag == tag_i) && !res_q.hit) begin
        res_d.hit      = 1'b1;
        res_d.hit_way  = way_i;
        res_d.hit_rank = entry_i.rank;
      end
      if (!entry_i.valid && !res_q.inv) begin
        res_d.inv     = 1'b1;
        res_d.inv_way = way_i;
      end
      if (entry_i.rank > res_q.max_rank) begin
        res_d.max_rank = entry_i.rank;
        res_d.max_way  = way_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: sim/tb_set_assoc_lru_cache_hit_model.sv
`timescale 1ns / 100ps
// Testbench for set_assoc_lru_cache_hit_model: directed table, then random phases.
// Needs slac_pkg, slac_req_if, slac_rsp_if and the block's RTL.
// Results are checked against a tag, valid and LRU rank predictor kept in this file.

module tb_set_assoc_lru_cache_hit_model;
  import slac_pkg::*;

  localparam int unsigned LineBytes     = 1 << OffsBits;
  localparam logic        OpLoad        = ~OpStore;
  localparam logic [1:0]  PfReserved    = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = CfgIdxW'(5);
  localparam int unsigned NumPhases     = 9;
  localparam int unsigned PhaseItems    = 72;
  localparam int unsigned PoolSize      = 8;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SettleCycles  = 80;
  localparam int unsigned TimeoutNs     = 8_000_000;

  typedef struct packed {
    logic              hit;
    logic              prefetch_present;
    logic [CountW-1:0] hit_count;
  } lookup_t;

  typedef enum logic {StepAccess, StepWrite} step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                op;
    logic [AddrW-1:0]    addr;
    logic                typed;
    lookup_t             want;
  } step_t;

  localparam lookup_t Unchecked = '0;
  localparam int unsigned NumSteps = 34;
  localparam step_t DirectedPlan [NumSteps] = '{
    '{StepAccess, '0, '0, OpLoad,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'd0}},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_001F, 1'b1, '{1'b1, 1'b0, 32'd1}},
    '{StepAccess, '0, '0, OpStore, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'd1}},
    '{StepAccess, '0, '0, OpStore, 32'hFFFF_FFE0, 1'b1, '{1'b1, 1'b0, 32'd2}},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_2000, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_4000, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_0000, 1'b0, Unchecked},
    '{StepWrite, CfgPrefetch, CfgDataW'(PfAlways), OpLoad, '0, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_0100, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_0120, 1'b0, Unchecked},
    '{StepWrite, CfgPrefetch, CfgDataW'(PfOnMiss), OpLoad, '0, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'hFFFF_FFE0, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'hFFFF_FFC0, 1'b0, Unchecked},
    '{StepWrite, CfgAlloc, CfgDataW'(1'b0), OpLoad, '0, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpStore, 32'h0000_8000, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpStore, 32'h0000_8000, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_8000, 1'b0, Unchecked},
    '{StepWrite, CfgPrefetch, CfgDataW'(PfReserved), OpLoad, '0, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_8020, 1'b0, Unchecked},
    '{StepWrite, CfgUnused, CfgDataW'(4'hF), OpLoad, '0, 1'b0, Unchecked},
    '{StepWrite, CfgCacheSize, CfgDataW'(4'd0), OpLoad, '0, 1'b0, Unchecked},
    '{StepWrite, CfgWays, CfgDataW'(4'd7), OpLoad, '0, 1'b0, Unchecked},
    '{StepWrite, CfgPrefetch, CfgDataW'(PfAlways), OpLoad, '0, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'hFFFF_FFE0, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_0000, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpStore, 32'h0000_0040, 1'b0, Unchecked},
    '{StepWrite, CfgCacheSize, CfgDataW'(SizeLog2Max), OpLoad, '0, 1'b0, Unchecked},
    '{StepWrite, CfgWays, CfgDataW'(3'd0), OpLoad, '0, 1'b0, Unchecked},
    '{StepWrite, CfgAlloc, CfgDataW'(1'b1), OpLoad, '0, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_0000, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_8000, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h0000_0000, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpStore, 32'h7FFF_FFFF, 1'b0, Unchecked},
    '{StepAccess, '0, '0, OpLoad,  32'h8000_0000, 1'b0, Unchecked}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  slac_req_if req_if ();
  slac_rsp_if rsp_if ();

  set_assoc_lru_cache_hit_model dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [TagW-1:0]  tag_mdl  [NumEntries];
  logic             vld_mdl  [NumEntries];
  logic [RankW-1:0] rank_mdl [NumEntries];
  logic [CountW-1:0] hits_mdl;
  logic [3:0]       size_reg;
  logic [2:0]       ways_reg;
  logic             alloc_reg;
  logic [1:0]       pf_reg;
  int unsigned      n_ways;
  int unsigned      n_sets;
  int unsigned      size_eff;

  lookup_t          pending_lookups [$];
  int unsigned      mismatches = 0;
  int unsigned      send_idle_pct = 18;
  int unsigned      recv_idle_pct = 52;
  bit               hold_wanted = 1'b0;
  bit               hold_started = 1'b0;
  int unsigned      hold_left = 0;
  logic [AddrW-1:0] addr_pool [PoolSize];
  logic [AddrW-1:0] last_addr = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(TimeoutNs);
    $display("== FAIL ==");
    $finish;
  end

  function automatic void update_geometry();
    int unsigned lines;
    int unsigned wl;
    size_eff = size_reg;
    if (size_eff < SizeLog2Min) size_eff = SizeLog2Min;
    if (size_eff > SizeLog2Max) size_eff = SizeLog2Max;
    lines = (1 << size_eff) / LineBytes;
    if (lines > NumEntries) lines = NumEntries;
    wl = ways_reg;
    if (wl > WaysLog2Max) wl = WaysLog2Max;
    n_ways = 1 << wl;
    if (n_ways > lines) n_ways = lines;
    n_sets = lines / n_ways;
  endfunction

  function automatic void invalidate_all();
    for (int unsigned e = 0; e < NumEntries; e++) begin
      tag_mdl[e]  = '0;
      vld_mdl[e]  = 1'b0;
      rank_mdl[e] = '0;
    end
  endfunction

  function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] data);
    case (idx)
      CfgCacheSize: begin
        size_reg = data;
        invalidate_all();
      end
      CfgWays: begin
        ways_reg = data[2:0];
        invalidate_all();
      end
      CfgAlloc: alloc_reg = data[0];
      CfgPrefetch: pf_reg = data[1:0];
      default: ;
    endcase
    update_geometry();
  endfunction

  function automatic void split_line(input logic [AddrW-1:0] addr, output int unsigned base,
                                     output logic [TagW-1:0] tag);
    int unsigned line;
    line = addr >> OffsBits;
    tag  = TagW'(line / n_sets);
    base = (line % n_sets) * n_ways;
  endfunction

  function automatic int find_way(input int unsigned base, input logic [TagW-1:0] tag);
    for (int unsigned w = 0; w < n_ways; w++) begin
      if (vld_mdl[base + w] && tag_mdl[base + w] == tag) return int'(w);
    end
    return -1;
  endfunction

  function automatic void touch_way(input int unsigned base, input int unsigned way);
    int unsigned limit;
    limit = vld_mdl[base + way] ? rank_mdl[base + way] : n_ways;
    for (int unsigned v = 0; v < n_ways; v++) begin
      if (v != way && vld_mdl[base + v] && rank_mdl[base + v] < limit &&
          rank_mdl[base + v] != RankMax) begin
        rank_mdl[base + v] = rank_mdl[base + v] + 1'b1;
      end
    end
    rank_mdl[base + way] = '0;
  endfunction

  function automatic void fill_line(input int unsigned base, input logic [TagW-1:0] tag);
    int unsigned victim;
    int unsigned best;
    bit found;
    victim = 0;
    found = 1'b0;
    for (int unsigned w = 0; w < n_ways; w++) begin
      if (!found && !vld_mdl[base + w]) begin
        victim = w;
        found = 1'b1;
      end
    end
    if (!found) begin
      best = 0;
      for (int unsigned w = 0; w < n_ways; w++) begin
        if (rank_mdl[base + w] > best) begin
          best = rank_mdl[base + w];
          victim = w;
        end
      end
    end
    touch_way(base, victim);
    tag_mdl[base + victim] = tag;
    vld_mdl[base + victim] = 1'b1;
  endfunction

  function automatic lookup_t cache_lookup(input logic op, input logic [AddrW-1:0] addr);
    lookup_t res;
    int unsigned dbase;
    int unsigned pbase;
    logic [TagW-1:0] dtag;
    logic [TagW-1:0] ptag;
    int dway;
    int pway;
    bit probe;
    split_line(addr, dbase, dtag);
    split_line(addr + AddrW'(LineBytes), pbase, ptag);
    res = '0;
    dway = find_way(dbase, dtag);
    res.hit = (dway >= 0);
    if (res.hit) begin
      touch_way(dbase, dway);
      if (hits_mdl != '1) hits_mdl = hits_mdl + 1'b1;
    end
    probe = (pf_reg == PfAlways) || (pf_reg == PfOnMiss && !res.hit);
    if (probe) begin
      pway = find_way(pbase, ptag);
      res.prefetch_present = (pway >= 0);
      if (res.prefetch_present) touch_way(pbase, pway);
    end
    if (!res.hit && (op != OpStore || alloc_reg)) fill_line(dbase, dtag);
    if (probe && !res.prefetch_present) fill_line(pbase, ptag);
    res.hit_count = hits_mdl;
    return res;
  endfunction

  function automatic logic [AddrW-1:0] pick_address();
    int unsigned r;
    logic [AddrW-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      a = $urandom;
    end else if (r < 40) begin
      a = last_addr + AddrW'($urandom_range(0, 63));
    end else begin
      a = addr_pool[$urandom_range(0, PoolSize - 1)] +
          (AddrW'($urandom_range(0, 3)) << size_eff) + AddrW'($urandom_range(0, 31));
    end
    last_addr = a;
    return a;
  endfunction

  function automatic void enqueue_lookup(input lookup_t item);
    pending_lookups.insert(pending_lookups.size(), item);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic issue_access(input logic op, input logic [AddrW-1:0] addr, input logic typed,
                              input lookup_t typed_want);
    lookup_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.address <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    want = cache_lookup(op, addr);
    if (typed) want = typed_want;
    enqueue_lookup(want);
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_wanted && !hold_started) begin
      hold_left = HoldCycles;
      hold_started = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("response transfer with no request outstanding");
      end else begin
        want = pending_lookups.pop_front();
        if (rsp_if.hit !== want.hit) begin
          report_mismatch($sformatf("hit: expected %0b, got %0b", want.hit, rsp_if.hit));
        end
        if (rsp_if.prefetch_present !== want.prefetch_present) begin
          report_mismatch($sformatf("prefetch_present: expected %0b, got %0b",
                                    want.prefetch_present, rsp_if.prefetch_present));
        end
        if (rsp_if.hit_count !== want.hit_count) begin
          report_mismatch($sformatf("hit_count: expected %0d, got %0d",
                                    want.hit_count, rsp_if.hit_count));
        end
      end
    end
  end

  initial begin
    logic [3:0] size_val;
    logic [2:0] ways_val;
    req_if.valid   = 1'b0;
    req_if.opcode  = OpLoad;
    req_if.address = '0;
    rsp_if.ready   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    rst_ni         = 1'b0;
    size_reg  = SizeLog2Rst;
    ways_reg  = WaysLog2Rst;
    alloc_reg = AllocRst;
    pf_reg    = PfOff;
    hits_mdl  = '0;
    invalidate_all();
    update_geometry();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumSteps; i++) begin
      if (DirectedPlan[i].kind == StepWrite) begin
        wait_for_drain();
        write_register(DirectedPlan[i].idx, DirectedPlan[i].data);
      end else begin
        issue_access(DirectedPlan[i].op, DirectedPlan[i].addr, DirectedPlan[i].typed,
                     DirectedPlan[i].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_for_drain();
      case (p * 3 / NumPhases)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: begin
          size_val = SizeLog2Min;
          ways_val = WaysLog2Max;
        end
        1: begin
          size_val = SizeLog2Max;
          ways_val = 3'd0;
        end
        2: begin
          size_val = SizeLog2Max;
          ways_val = WaysLog2Max;
        end
        default: begin
          size_val = 4'($urandom_range(8, 15));
          ways_val = 3'($urandom_range(0, 7));
        end
      endcase
      write_register(CfgCacheSize, CfgDataW'(size_val));
      write_register(CfgWays, CfgDataW'(ways_val));
      write_register(CfgAlloc, CfgDataW'($urandom_range(0, 1)));
      write_register(CfgPrefetch, CfgDataW'($urandom_range(0, 3)));
      addr_pool[0] = 32'hFFFF_FFC0;
      for (int k = 1; k < PoolSize; k++) addr_pool[k] = $urandom & ~AddrW'(LineBytes - 1);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 0 && n == 8) hold_wanted = 1'b1;
        issue_access(1'($urandom_range(0, 1)), pick_address(), 1'b0, Unchecked);
      end
    end

    wait_for_drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
